[design/mtstk_pkg.sv]
// package for the min-tracking stack: sizes, opcodes, status codes and types
// shared by the controller, the datapath and the top level
// depends on nothing
`timescale 1ns / 1ps

package mtstk_pkg;

    // stack geometry
    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    // field widths
    localparam int DATA_W = 32;
    localparam int OCC_W  = 7;

    // opcodes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // minimum reported for an empty stack
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // input item
    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] value;
    } t_in;

    // result item
    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     is_empty;
        logic [OCC_W-1:0]         occupancy;
        logic [1:0]               status;
    } t_out;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       accept;
        logic       push;
        logic       pop;
        logic       load_top;
        logic       load_out;
        logic [1:0] status_code;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic one;
        logic out_free;
    } t_dp_stat;

endpackage

[design/mtstk_ram.sv]
// generic single-port-write, single-port-read RAM with registered read data
// depends on nothing
`timescale 1ns / 1ps

module mtstk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/mtstk_ctrl.sv]
// controller for the min-tracking stack: sequences accept, entry read-back
// and result hand-off; uses mtstk_pkg
`timescale 1ns / 1ps

module mtstk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_opcode,
    input  mtstk_pkg::t_dp_stat i_stat,
    output logic                o_ready,
    output mtstk_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]      r_state;
    logic [1:0]      n_state;
    mtstk_pkg::t_cmd w_cmd;
    logic            w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);

    // command decode and next state
    always_comb begin
        w_cmd             = '0;
        w_cmd.accept      = w_accept;
        w_cmd.status_code = mtstk_pkg::ST_OK;
        n_state           = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_FIN;
                    if (i_opcode == mtstk_pkg::OP_PUSH) begin
                        if (i_stat.full) begin
                            w_cmd.status_code = mtstk_pkg::ST_FULL;
                        end else begin
                            w_cmd.push = 1'b1;
                        end
                    end else if (i_opcode == mtstk_pkg::OP_POP) begin
                        if (i_stat.empty) begin
                            w_cmd.status_code = mtstk_pkg::ST_EMPTY;
                        end else begin
                            w_cmd.pop = 1'b1;
                            // new top lies in memory unless the stack empties
                            if (!i_stat.one) begin
                                n_state = S_READ;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                w_cmd.load_top = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = w_cmd;

endmodule

[design/mtstk_dp.sv]
// datapath for the min-tracking stack: entry count, cached top entry,
// entry memory and the result register; uses mtstk_pkg and mtstk_ram
`timescale 1ns / 1ps

module mtstk_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtstk_pkg::t_in      i_data,
    input  mtstk_pkg::t_cmd     i_cmd,
    input  logic                i_out_ready,
    output mtstk_pkg::t_dp_stat o_stat,
    output logic                o_out_valid,
    output mtstk_pkg::t_out     o_out
);

    localparam int ENTRY_W = 2 * mtstk_pkg::DATA_W;

    logic [mtstk_pkg::CNT_W-1:0]            r_count;
    logic signed [mtstk_pkg::DATA_W-1:0]    r_top_val;
    logic signed [mtstk_pkg::DATA_W-1:0]    r_top_min;
    logic [1:0]                             r_status;
    logic                                   r_out_valid;
    mtstk_pkg::t_out                        r_out;

    logic                                   w_empty;
    logic                                   w_full;
    logic signed [mtstk_pkg::DATA_W-1:0]    w_below;
    logic signed [mtstk_pkg::DATA_W-1:0]    w_new_min;
    logic [ENTRY_W-1:0]                     w_rdata;
    logic [mtstk_pkg::ADDR_W-1:0]           w_waddr;
    logic [mtstk_pkg::ADDR_W-1:0]           w_raddr;
    logic                                   w_out_free;

    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == mtstk_pkg::CNT_W'(mtstk_pkg::DEPTH));
    assign w_out_free = !r_out_valid || i_out_ready;

    // running minimum of the pushed value and the entries below
    assign w_below   = w_empty ? mtstk_pkg::INT_MAX : r_top_min;
    assign w_new_min = (i_data.value < w_below) ? i_data.value : w_below;

    // push writes at the count, pop reads the entry below the old top
    assign w_waddr = r_count[mtstk_pkg::ADDR_W-1:0];
    assign w_raddr = mtstk_pkg::ADDR_W'(r_count - mtstk_pkg::CNT_W'(2));

    mtstk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (mtstk_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_waddr),
        .i_wdata ({w_new_min, i_data.value}),
        .i_re    (i_cmd.pop),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + mtstk_pkg::CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - mtstk_pkg::CNT_W'(1);
        end
    end

    // cached top entry and status of the item in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top_val <= i_data.value;
            r_top_min <= w_new_min;
        end else if (i_cmd.load_top) begin
            r_top_val <= w_rdata[mtstk_pkg::DATA_W-1:0];
            r_top_min <= w_rdata[ENTRY_W-1:mtstk_pkg::DATA_W];
        end
        if (i_cmd.accept) begin
            r_status <= i_cmd.status_code;
        end
    end

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.top_value <= w_empty ? '0 : r_top_val;
            r_out.min_value <= w_empty ? mtstk_pkg::INT_MAX : r_top_min;
            r_out.is_empty  <= w_empty;
            r_out.occupancy <= mtstk_pkg::OCC_W'(r_count);
            r_out.status    <= r_status;
        end
    end

    assign o_stat.full     = w_full;
    assign o_stat.empty    = w_empty;
    assign o_stat.one      = (r_count == mtstk_pkg::CNT_W'(1));
    assign o_stat.out_free = w_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule

[design/min_tracking_stack.sv]
// top level of the min-tracking stack: joins controller and datapath
// uses mtstk_pkg, mtstk_ctrl and mtstk_dp
//
// A LIFO of 64 signed 32-bit entries that also reports the running minimum.
// Input channel (i_valid/o_ready, i_data): one transfer per operation, an
// opcode of push, pop or peek plus the value to push. Output channel
// (o_valid/i_ready, o_data): exactly one transfer per operation, giving the
// top entry, the minimum, an empty flag, the occupancy and a status after
// the operation. An empty stack reports top 0 and minimum 2147483647.
// Operations do not overlap: o_ready is low from acceptance until the result
// is loaded into the output register. A pop that leaves entries passes
// through an extra read state, since the new top is fetched from the entry
// memory through its registered read port. A result is loaded into the
// output register once that register is free.
// The result sits in an output register; a stalled receiver holds it there
// and the next operation is processed meanwhile, waiting only to hand over
// its own result. Synchronous active-low reset empties the stack and drops
// any pending result; the memory itself is not cleared.
`timescale 1ns / 1ps

module min_tracking_stack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mtstk_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output mtstk_pkg::t_out o_data
);

    mtstk_pkg::t_cmd     w_cmd;
    mtstk_pkg::t_dp_stat w_stat;

    mtstk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_data.opcode),
        .i_stat   (w_stat),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    mtstk_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_valid),
        .o_out       (o_data)
    );

endmodule
